// ----- rtl/small_matrix_inverse_macros.svh -----
// Assertion macros for the small matrix inverse block
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH
`ifndef SYNTHESIS
`define SMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("smi: same-cycle check failed");
`define SMI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("smi: next-cycle check failed");
`else
`define SMI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SMI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/smi_pkg.sv -----
// Types, constants and stage map shared by the small matrix inverse block
package smi_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned DET_W     = 3 * DATA_W + 2;
    localparam int unsigned NUM_W     = PROD_W + 2 * FRAC_BITS;
    localparam int unsigned QBITS     = DATA_W + 1;
    localparam int unsigned N_ENT     = 9;
    localparam int unsigned N_PROD    = 2 * N_ENT;
    localparam int unsigned N_DTERM   = 3;

    // pipeline stage map
    localparam int unsigned ST_IN    = 0;
    localparam int unsigned ST_PROD  = 1;
    localparam int unsigned ST_COF   = 2;
    localparam int unsigned ST_DPART = 3;
    localparam int unsigned ST_TERM  = 4;
    localparam int unsigned ST_DET   = 5;
    localparam int unsigned ST_MAG   = 6;
    localparam int unsigned ST_DIV0  = 7;
    localparam int unsigned ST_RND   = ST_DIV0 + QBITS + 1;
    localparam int unsigned ST_OUT   = ST_RND + 1;
    localparam int unsigned N_ST     = ST_OUT + 1;
    localparam int unsigned N_DSTG   = QBITS + 2;
    localparam int unsigned N_ZSTG   = QBITS + 3;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PROD_W:0]   t_plo;
    typedef logic [DET_W-1:0]         t_dmag;
    typedef logic [PROD_W-1:0]        t_mag;
    typedef logic [N_ST-1:0]          t_ld;
    typedef logic [3:0]               t_eidx;

    typedef struct packed {
        logic  sat;
        t_word val;
    } t_lane_res;

    // flat entry index, row * 3 + column
    localparam t_eidx E_R0C0 = 4'd0;
    localparam t_eidx E_R0C1 = 4'd1;
    localparam t_eidx E_R0C2 = 4'd2;
    localparam t_eidx E_R1C0 = 4'd3;
    localparam t_eidx E_R1C1 = 4'd4;
    localparam t_eidx E_R1C2 = 4'd5;
    localparam t_eidx E_R2C0 = 4'd6;
    localparam t_eidx E_R2C1 = 4'd7;
    localparam t_eidx E_R2C2 = 4'd8;

    // cofactor k = PROD_X[2k]*PROD_Y[2k] - PROD_X[2k+1]*PROD_Y[2k+1]
    localparam t_eidx PROD_X [N_PROD] = '{
        E_R1C1, E_R1C2, E_R0C2, E_R0C1, E_R0C1, E_R0C2,
        E_R1C2, E_R1C0, E_R0C0, E_R0C2, E_R0C2, E_R0C0,
        E_R1C0, E_R1C1, E_R0C1, E_R0C0, E_R0C0, E_R0C1};
    localparam t_eidx PROD_Y [N_PROD] = '{
        E_R2C2, E_R2C1, E_R2C1, E_R2C2, E_R1C2, E_R1C1,
        E_R2C0, E_R2C2, E_R2C2, E_R2C0, E_R1C0, E_R1C2,
        E_R2C1, E_R2C0, E_R2C0, E_R2C1, E_R1C1, E_R1C0};

    // determinant expands along row 0
    localparam t_eidx DET_A   [N_DTERM] = '{E_R0C0, E_R0C1, E_R0C2};
    localparam t_eidx DET_COF [N_DTERM] = '{E_R0C0, E_R1C0, E_R2C0};

    localparam logic [QBITS:0] LIM_NEG =
        {{(QBITS + 1 - DATA_W){1'b0}}, 1'b1, {(DATA_W - 1){1'b0}}};
    localparam logic [QBITS:0] LIM_POS = LIM_NEG - 1'b1;

endpackage

// ----- rtl/smi_if.sv -----
// Valid/ready channel interfaces for matrix beats and inverse beats
interface smi_in_if import smi_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  mode;
    t_word a_r0c0;
    t_word a_r0c1;
    t_word a_r0c2;
    t_word a_r1c0;
    t_word a_r1c1;
    t_word a_r1c2;
    t_word a_r2c0;
    t_word a_r2c1;
    t_word a_r2c2;

    modport source (
        output valid, mode, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        input  ready
    );
    modport sink (
        input  valid, mode, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
               a_r2c0, a_r2c1, a_r2c2,
        output ready
    );
endinterface

interface smi_out_if import smi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word inv_r0c0;
    t_word inv_r0c1;
    t_word inv_r0c2;
    t_word inv_r1c0;
    t_word inv_r1c1;
    t_word inv_r1c2;
    t_word inv_r2c0;
    t_word inv_r2c1;
    t_word inv_r2c2;
    logic  singular;
    logic  saturated;

    modport source (
        output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        input  ready
    );
    modport sink (
        input  valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2,
               inv_r2c0, inv_r2c1, inv_r2c2, singular, saturated,
        output ready
    );
endinterface

// ----- rtl/smi_front.sv -----
// Front end: input register, cofactor products and exact determinant
module smi_front import smi_pkg::*; (
    input  logic  i_clk,
    input  t_ld   i_ld,
    input  logic  i_mode,
    input  t_word i_a   [N_ENT],
    output t_prod o_cof [N_ENT],
    output t_dmag o_det
);

    logic  r_mode0, r_mode1, r_mode2, r_mode3, r_mode4;
    t_word r_a0 [N_ENT];
    t_prod r_p  [N_PROD];
    t_word r_a00_1, r_a01_1, r_a02_1, r_a10_1, r_a11_1;
    t_word r_a2 [N_DTERM];
    t_prod r_cof2 [N_ENT];
    t_prod r_cof3 [N_ENT];
    t_prod r_cof4 [N_ENT];
    t_prod r_cof5 [N_ENT];
    t_prod r_det2_2, r_det2_3, r_det2_4;
    t_plo  r_pl [N_DTERM];
    t_prod r_ph [N_DTERM];
    t_dmag r_term [N_DTERM];
    t_dmag r_det;
    t_prod n_cof [N_ENT];
    t_prod n_diff [N_ENT];
    t_dmag n_det;

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_IN]) begin
            r_mode0 <= i_mode;
            r_a0    <= i_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_PROD]) begin
            for (int k = 0; k < N_PROD; k++) begin
                r_p[k] <= r_a0[PROD_X[k]] * r_a0[PROD_Y[k]];
            end
            r_mode1 <= r_mode0;
            r_a00_1 <= r_a0[E_R0C0];
            r_a01_1 <= r_a0[E_R0C1];
            r_a02_1 <= r_a0[E_R0C2];
            r_a10_1 <= r_a0[E_R1C0];
            r_a11_1 <= r_a0[E_R1C1];
        end
    end

    always_comb begin
        for (int k = 0; k < N_ENT; k++) begin
            n_diff[k] = r_p[2*k] - r_p[2*k+1];
        end
        if (r_mode1) begin
            n_cof = n_diff;
        end else begin
            for (int k = 0; k < N_ENT; k++) begin
                n_cof[k] = '0;
            end
            n_cof[E_R0C0] = t_prod'(r_a11_1);
            n_cof[E_R0C1] = -t_prod'(r_a01_1);
            n_cof[E_R1C0] = -t_prod'(r_a10_1);
            n_cof[E_R1C1] = t_prod'(r_a00_1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_COF]) begin
            r_cof2   <= n_cof;
            r_det2_2 <= n_diff[E_R2C2];  // 2x2 determinant
            r_mode2  <= r_mode1;
            r_a2[0]  <= r_a00_1;
            r_a2[1]  <= r_a01_1;
            r_a2[2]  <= r_a02_1;
        end
    end

    // 32 x 64 products split into low (unsigned) and high (signed) halves
    always_ff @(posedge i_clk) begin
        if (i_ld[ST_DPART]) begin
            for (int j = 0; j < N_DTERM; j++) begin
                r_pl[j] <= r_a2[j] * $signed({1'b0, r_cof2[DET_COF[j]][DATA_W-1:0]});
                r_ph[j] <= r_a2[j] * $signed(r_cof2[DET_COF[j]][PROD_W-1:DATA_W]);
            end
            r_cof3   <= r_cof2;
            r_det2_3 <= r_det2_2;
            r_mode3  <= r_mode2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_TERM]) begin
            for (int j = 0; j < N_DTERM; j++) begin
                r_term[j] <= ({{(DET_W - PROD_W){r_ph[j][PROD_W-1]}}, r_ph[j]} << DATA_W)
                           + {{(DET_W - PROD_W - 1){r_pl[j][PROD_W]}}, r_pl[j]};
            end
            r_cof4   <= r_cof3;
            r_det2_4 <= r_det2_3;
            r_mode4  <= r_mode3;
        end
    end

    always_comb begin
        if (r_mode4) begin
            n_det = r_term[0] + r_term[1] + r_term[2];
        end else begin
            n_det = {{(DET_W - PROD_W){r_det2_4[PROD_W-1]}}, r_det2_4};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_DET]) begin
            r_det  <= n_det;
            r_cof5 <= r_cof4;
        end
    end

    assign o_cof = r_cof5;
    assign o_det = r_det;

endmodule

// ----- rtl/smi_lane.sv -----
// One divider lane: restoring division one quotient bit per stage, round, saturate
module smi_lane import smi_pkg::*; (
    input  logic      i_clk,
    input  t_ld       i_ld,
    input  t_mag      i_mag,
    input  logic      i_neg,
    input  t_dmag     i_d [N_DSTG],
    output t_lane_res o_res
);

    t_dmag            r_rem [QBITS+1];
    logic [QBITS-1:0] r_q   [QBITS+1];
    logic [QBITS-1:0] r_nlo [QBITS];
    logic             r_ovf [QBITS+1];
    logic             r_ng  [QBITS+1];
    t_lane_res        r_res;
    logic [NUM_W-1:0] n_num;
    t_dmag            n_top;
    logic             n_up;
    logic [QBITS:0]   n_qr;
    logic [QBITS:0]   n_lim;
    logic             n_sat;
    t_word            n_m;

    assign n_num = {i_mag, {(2 * FRAC_BITS){1'b0}}};
    assign n_top = DET_W'(n_num[NUM_W-1:QBITS]);

    // entry: a quotient of 2^QBITS or more saturates
    always_ff @(posedge i_clk) begin
        if (i_ld[ST_DIV0]) begin
            r_rem[0] <= n_top;
            r_ovf[0] <= n_top >= i_d[0];
            r_nlo[0] <= n_num[QBITS-1:0];
            r_q[0]   <= '0;
            r_ng[0]  <= i_neg;
        end
    end

    for (genvar j = 0; j < QBITS; j++) begin : g_step
        logic [DET_W:0] w_t;
        logic [DET_W:0] w_sub;
        logic           w_ge;

        assign w_t   = {r_rem[j], r_nlo[j][QBITS-1]};
        assign w_sub = w_t - {1'b0, i_d[j+1]};
        assign w_ge  = w_t >= {1'b0, i_d[j+1]};

        always_ff @(posedge i_clk) begin
            if (i_ld[ST_DIV0 + 1 + j]) begin
                r_rem[j+1] <= w_ge ? w_sub[DET_W-1:0] : w_t[DET_W-1:0];
                r_q[j+1]   <= {r_q[j][QBITS-2:0], w_ge};
                r_ovf[j+1] <= r_ovf[j];
                r_ng[j+1]  <= r_ng[j];
            end
        end

        if (j < QBITS - 1) begin : g_nlo
            always_ff @(posedge i_clk) begin
                if (i_ld[ST_DIV0 + 1 + j]) begin
                    r_nlo[j+1] <= {r_nlo[j][QBITS-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero on the magnitude, then clip
    always_comb begin
        n_up  = {r_rem[QBITS], 1'b0} >= {1'b0, i_d[QBITS+1]};
        n_qr  = {1'b0, r_q[QBITS]} + {{QBITS{1'b0}}, n_up};
        n_lim = r_ng[QBITS] ? LIM_NEG : LIM_POS;
        n_sat = r_ovf[QBITS] || (n_qr > n_lim);
        n_m   = n_sat ? n_lim[DATA_W-1:0] : n_qr[DATA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_RND]) begin
            r_res.sat <= n_sat;
            r_res.val <= r_ng[QBITS] ? -n_m : n_m;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/small_matrix_inverse.sv -----
// Top level of the small matrix inverse block: pipeline control, lanes and merge
//
// Input channel i_in carries one whole 2x2 (mode 0) or 3x3 (mode 1) matrix per
// beat in signed fixed point with FRAC_BITS fraction bits. Output channel o_out
// carries the nine inverse entries of that matrix per beat, unused entries zero
// in 2x2 mode, plus a singular flag (zero determinant, all entries zero) and a
// saturated flag (an entry was clipped to the 32-bit range).
// Beats are taken when valid and ready are both high; results leave in order.
// Throughput: one matrix per cycle while the output is not stalled. Cofactors
// and the determinant take six stages; nine divider lanes then run one quotient
// bit per stage over 33 stages, followed by a round stage and the merge
// register. The divider depth sets the latency.
// Each stage holds its beat while the stages after it are full and stalled,
// so a stalled receiver fills the pipeline's empty slots before ready drops.
// Reset (synchronous, active low) empties the pipeline; no result is lost or
// repeated across a stall.
`include "small_matrix_inverse_macros.svh"
module small_matrix_inverse import smi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    smi_in_if.sink    i_in,
    smi_out_if.source o_out
);

    t_ld       r_vld;
    t_ld       n_vld;
    t_ld       ld;
    t_word     a_in [N_ENT];
    t_prod     cof  [N_ENT];
    t_dmag     det;
    t_dmag     r_d  [N_DSTG];
    logic      r_zero [N_ZSTG];
    t_mag      r_mag [N_ENT];
    logic      r_neg [N_ENT];
    t_lane_res lane_res [N_ENT];
    t_word     r_inv [N_ENT];
    logic      r_sing;
    logic      r_sat;
    logic      any_sat;

    // a stage loads when some stage at or after it is empty, or the output drains
    for (genvar s = 0; s < N_ST; s++) begin : g_ld
        assign ld[s] = o_out.ready || !(&r_vld[N_ST-1:s]);
    end

    assign n_vld      = {r_vld[N_ST-2:0], i_in.valid};
    assign i_in.ready = ld[ST_IN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_ST; s++) begin
                if (ld[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    assign a_in[E_R0C0] = i_in.a_r0c0;
    assign a_in[E_R0C1] = i_in.a_r0c1;
    assign a_in[E_R0C2] = i_in.a_r0c2;
    assign a_in[E_R1C0] = i_in.a_r1c0;
    assign a_in[E_R1C1] = i_in.a_r1c1;
    assign a_in[E_R1C2] = i_in.a_r1c2;
    assign a_in[E_R2C0] = i_in.a_r2c0;
    assign a_in[E_R2C1] = i_in.a_r2c1;
    assign a_in[E_R2C2] = i_in.a_r2c2;

    smi_front u_front (
        .i_clk  (i_clk),
        .i_ld   (ld),
        .i_mode (i_in.mode),
        .i_a    (a_in),
        .o_cof  (cof),
        .o_det  (det)
    );

    // magnitudes and result signs
    always_ff @(posedge i_clk) begin
        if (ld[ST_MAG]) begin
            r_d[0]    <= det[DET_W-1] ? -det : det;
            r_zero[0] <= det == '0;
            for (int i = 0; i < N_ENT; i++) begin
                r_mag[i] <= cof[i][PROD_W-1] ? -t_mag'(cof[i]) : t_mag'(cof[i]);
                r_neg[i] <= cof[i][PROD_W-1] ^ det[DET_W-1];
            end
        end
    end

    // divisor and singular flag ride alongside the lanes
    for (genvar k = 1; k < N_ZSTG; k++) begin : g_dpipe
        always_ff @(posedge i_clk) begin
            if (ld[ST_MAG + k]) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
        if (k < N_DSTG) begin : g_d
            always_ff @(posedge i_clk) begin
                if (ld[ST_MAG + k]) begin
                    r_d[k] <= r_d[k-1];
                end
            end
        end
    end

    for (genvar i = 0; i < N_ENT; i++) begin : g_lane
        smi_lane u_lane (
            .i_clk (i_clk),
            .i_ld  (ld),
            .i_mag (r_mag[i]),
            .i_neg (r_neg[i]),
            .i_d   (r_d),
            .o_res (lane_res[i])
        );
    end

    always_comb begin
        any_sat = 1'b0;
        for (int i = 0; i < N_ENT; i++) begin
            any_sat = any_sat | lane_res[i].sat;
        end
    end

    // merge: singular forces zeros and clears the clip flag
    always_ff @(posedge i_clk) begin
        if (ld[ST_OUT]) begin
            for (int i = 0; i < N_ENT; i++) begin
                r_inv[i] <= r_zero[N_ZSTG-1] ? '0 : lane_res[i].val;
            end
            r_sing <= r_zero[N_ZSTG-1];
            r_sat  <= !r_zero[N_ZSTG-1] && any_sat;
        end
    end

    assign o_out.valid     = r_vld[N_ST-1];
    assign o_out.inv_r0c0  = r_inv[E_R0C0];
    assign o_out.inv_r0c1  = r_inv[E_R0C1];
    assign o_out.inv_r0c2  = r_inv[E_R0C2];
    assign o_out.inv_r1c0  = r_inv[E_R1C0];
    assign o_out.inv_r1c1  = r_inv[E_R1C1];
    assign o_out.inv_r1c2  = r_inv[E_R1C2];
    assign o_out.inv_r2c0  = r_inv[E_R2C0];
    assign o_out.inv_r2c1  = r_inv[E_R2C1];
    assign o_out.inv_r2c2  = r_inv[E_R2C2];
    assign o_out.singular  = r_sing;
    assign o_out.saturated = r_sat;

    // input only stalls behind a full pipe with a held result
    `SMI_ASSERT_IMP(a_stall_src, i_clk, i_rst_n, !i_in.ready, o_out.valid && !o_out.ready)
    `SMI_ASSERT_IMP(a_sing_zero, i_clk, i_rst_n, o_out.valid && o_out.singular, !o_out.saturated && o_out.inv_r0c0 == 0 && o_out.inv_r1c1 == 0 && o_out.inv_r2c2 == 0)
    `SMI_ASSERT_NXT(a_drain, i_clk, i_rst_n, o_out.valid && o_out.ready && !r_vld[N_ST-2], !o_out.valid)

endmodule
